FILE: src/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int PEND_W  = 2;
    localparam int PART_W  = 10;
    localparam int CONT_W  = 6;

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              is_error;
        logic              is_end;
    } t_result;

endpackage

FILE: src/utf8_to_utf16_decoder_core.sv
// Byte-serial UTF-8 to UTF-16 (BMP) decoder with registered, skid-buffered output.
//
// Usage:
//   Input channel: i_valid / o_stall carry one UTF-8 byte per item on i_data_byte.
//   Output channel: o_valid / i_stall carry one result item: o_code_unit,
//   o_is_error and o_is_end.
//   A lead byte of a multi-byte sequence and every continuation byte except the
//   last give no result; the last continuation byte gives the decoded code unit.
//   An ASCII byte gives its own result, a zero byte while idle gives an end
//   result, and a malformed byte gives an error result and clears the sequence.
//   Output: each result is registered in the output register before it appears.
//   Throughput: one byte per cycle while o_stall is low; the decode is a single
//   shallow stage between the sequence state and the output register.
//   Stall: a one-entry skid register catches a result produced while the
//   receiver stalls; o_stall rises only while that entry is full.
//   Reset: synchronous, active low; clears the sequence state and both result
//   slots, so the block starts idle with no pending bytes.
module utf8_to_utf16_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [u8u16_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [u8u16_pkg::UNIT_W-1:0]  o_code_unit,
    output logic                          o_is_error,
    output logic                          o_is_end
);
    import u8u16_pkg::*;

    logic [PEND_W-1:0] r_bytes_pending, n_bytes_pending;
    logic [PART_W-1:0] r_partial_value, n_partial_value;
    logic              r_out_valid, r_skid_valid;
    t_result           r_out, r_skid;

    logic              in_acc;
    logic              out_free;
    logic              res_valid;
    t_result           res;
    logic [UNIT_W-1:0] full_value;
    logic [PEND_W-1:0] pend_dec;

    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    assign full_value = {r_partial_value, i_data_byte[CONT_W-1:0]};
    assign pend_dec   = r_bytes_pending - PEND_ONE;

    always_comb begin
        res_valid       = 1'b0;
        res             = '0;
        n_bytes_pending = r_bytes_pending;
        n_partial_value = r_partial_value;
        if (r_bytes_pending == PEND_NONE) begin
            if (i_data_byte == '0) begin
                res_valid  = 1'b1;
                res.is_end = 1'b1;
            end else if (!i_data_byte[BYTE_W-1]) begin
                res_valid     = 1'b1;
                res.code_unit = UNIT_W'(i_data_byte);
            end else if (i_data_byte[BYTE_W-1 -: 3] == LEAD2_TAG) begin
                n_bytes_pending = PEND_ONE;
                n_partial_value = PART_W'(i_data_byte[4:0]);
            end else if (i_data_byte[BYTE_W-1 -: 4] == LEAD3_TAG) begin
                n_bytes_pending = PEND_TWO;
                n_partial_value = PART_W'(i_data_byte[3:0]);
            end else begin
                res_valid    = 1'b1;
                res.is_error = 1'b1;
            end
        end else if (i_data_byte[BYTE_W-1 -: 2] != CONT_TAG) begin
            res_valid       = 1'b1;
            res.is_error    = 1'b1;
            n_bytes_pending = PEND_NONE;
            n_partial_value = '0;
        end else begin
            n_bytes_pending = pend_dec;
            if (pend_dec == PEND_NONE) begin
                res_valid       = 1'b1;
                res.code_unit   = full_value;
                n_partial_value = '0;
            end else begin
                n_partial_value = full_value[PART_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_pending <= PEND_NONE;
            r_partial_value <= '0;
            r_out_valid     <= 1'b0;
            r_skid_valid    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_bytes_pending <= n_bytes_pending;
                r_partial_value <= n_partial_value;
            end
            if (out_free) begin
                r_skid_valid <= 1'b0;
                r_out_valid  <= r_skid_valid || (in_acc && res_valid);
            end else if (in_acc && res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_acc && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_code_unit = r_out.code_unit;
    assign o_is_error  = r_out.is_error;
    assign o_is_end    = r_out.is_end;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output item");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_error && o_is_end))
        else $error("error and end flagged together");

    a_flag_zero_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_is_error || o_is_end)) |-> (o_code_unit == '0))
        else $error("nonzero code unit on error or end item");

    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_valid && res.is_error) |=> (r_bytes_pending == PEND_NONE))
        else $error("sequence state kept after an error");

endmodule

FILE: tb/sv/tb_utf8_to_utf16_decoder_core.sv
// Self-checking testbench for the byte-serial UTF-8 to UTF-16 decoder core.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder_core;
    import u8u16_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int IDLE_LIMIT = 1000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [BYTE_W-1:0]   i_data_byte = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [UNIT_W-1:0]   o_code_unit;
    logic                o_is_error;
    logic                o_is_end;

    logic [PEND_W-1:0]   seq_pending = PEND_NONE;
    logic [PART_W-1:0]   seq_partial = '0;
    t_result             unit_q[$];

    bit                  gaps_on = 1'b0;
    bit                  stall_on = 1'b0;
    int                  stall_run = 0;
    int                  idle_cycles = 0;
    int                  mismatch_cnt = 0;
    int                  bytes_sent = 0;
    int                  units_seen = 0;
    int                  errors_seen = 0;
    int                  ends_seen = 0;

    utf8_to_utf16_decoder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_code_unit (o_code_unit),
        .o_is_error  (o_is_error),
        .o_is_end    (o_is_end)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 8);
        return $urandom_range(9, 24);
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        t_result           res;
        logic [UNIT_W-1:0] full;
        bit                give;
        res  = '0;
        give = 1'b0;
        if (seq_pending == PEND_NONE) begin
            if (b == '0) begin
                res.is_end = 1'b1;
                give = 1'b1;
            end else if (!b[7]) begin
                res.code_unit = {8'h00, b};
                give = 1'b1;
            end else if (b[7:5] == LEAD2_TAG) begin
                seq_pending = PEND_ONE;
                seq_partial = {5'b0, b[4:0]};
            end else if (b[7:4] == LEAD3_TAG) begin
                seq_pending = PEND_TWO;
                seq_partial = {6'b0, b[3:0]};
            end else begin
                res.is_error = 1'b1;
                give = 1'b1;
            end
        end else if (b[7:6] != CONT_TAG) begin
            seq_pending = PEND_NONE;
            seq_partial = '0;
            res.is_error = 1'b1;
            give = 1'b1;
        end else begin
            full = {seq_partial, b[CONT_W-1:0]};
            seq_pending = seq_pending - PEND_ONE;
            if (seq_pending == PEND_NONE) begin
                seq_partial = '0;
                res.code_unit = full;
                give = 1'b1;
            end else begin
                seq_partial = full[PART_W-1:0];
            end
        end
        if (give) unit_q.push_back(res);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        decode_byte(b);
        bytes_sent++;
        gap = (gaps_on && $urandom_range(0, 99) >= 55) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid     <= 1'b0;
            i_data_byte <= BYTE_W'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, got_v);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (unit_q.size() == 0) begin
                report_mismatch("unexpected result", 0, int'(o_code_unit));
            end else begin
                exp_r = unit_q.pop_front();
                if (o_code_unit !== exp_r.code_unit)
                    report_mismatch("code_unit", int'(exp_r.code_unit), int'(o_code_unit));
                if (o_is_error !== exp_r.is_error)
                    report_mismatch("is_error", int'(exp_r.is_error), int'(o_is_error));
                if (o_is_end !== exp_r.is_end)
                    report_mismatch("is_end", int'(exp_r.is_end), int'(o_is_end));
            end
            if (o_is_error) errors_seen++;
            else if (o_is_end) ends_seen++;
            else units_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!stall_on) begin
            i_stall <= 1'b0;
            stall_run = 0;
        end else if (stall_run == 0) begin
            if (!i_stall) begin
                i_stall <= 1'b1;
                stall_run = idle_len();
            end else begin
                i_stall <= 1'b0;
                stall_run = $urandom_range(1, 8);
            end
        end else begin
            stall_run--;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", unit_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_ascii_and_end();
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h7F);
    endtask

    task automatic test_two_byte();
        send_byte(8'hC0);
        send_byte(8'h80);
        send_byte(8'hDF);
        send_byte(8'hBF);
    endtask

    task automatic test_three_byte();
        send_byte(8'hE0);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'hEF);
        send_byte(8'hBF);
        send_byte(8'hBF);
    endtask

    task automatic test_malformed();
        send_byte(8'h80);
        send_byte(8'hF0);
        send_byte(8'hFF);
        send_byte(8'hC3);
        send_byte(8'h41);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'h00);
        send_byte(8'hE2);
        send_byte(8'hC3);
    endtask

    task automatic send_random_chunk();
        int                r;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            send_byte(BYTE_W'($urandom_range(1, 127)));
        end else if (r < 33) begin
            send_byte(8'h00);
        end else if (r < 55) begin
            send_byte(8'hC0 | BYTE_W'($urandom_range(0, 31)));
            send_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
        end else if (r < 80) begin
            send_byte(8'hE0 | BYTE_W'($urandom_range(0, 15)));
            send_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
            send_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
        end else if (r < 90) begin
            if ($urandom_range(0, 1)) begin
                send_byte(8'hC0 | BYTE_W'($urandom_range(0, 31)));
            end else begin
                send_byte(8'hE0 | BYTE_W'($urandom_range(0, 15)));
                if ($urandom_range(0, 1)) send_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
            end
            b = BYTE_W'($urandom_range(0, 255));
            if (b[7:6] == CONT_TAG) b[6] = 1'b1;
            send_byte(b);
        end else begin
            send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_drain_pause();
        repeat (6) send_random_chunk();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (unit_q.size() != 0);
    endtask

    task automatic test_random_stream(input int upto);
        while (bytes_sent < upto) send_random_chunk();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii_and_end();
        test_two_byte();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        test_three_byte();
        test_malformed();

        test_random_stream(300);
        test_drain_pause();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        test_random_stream(450);
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        test_drain_pause();
        test_random_stream(750);

        i_valid <= 1'b0;
        do @(posedge i_clk); while (unit_q.size() != 0);
        repeat (5) @(posedge i_clk);

        $display("Sent %0d bytes as valid, truncated and noisy UTF-8 under random gaps",
                 bytes_sent);
        $display("Checked %0d code units, %0d error and %0d end results",
                 units_seen, errors_seen, ends_seen);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/u8u16_pkg.sv
src/utf8_to_utf16_decoder_core.sv
tb/sv/tb_utf8_to_utf16_decoder_core.sv
